@@ src/scrp_pkg.sv @@
// Shared types and codes for the SOCKS client reply parser.
// Depends on nothing; every other file of the block imports it.
package scrp_pkg;

   // result events
   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_SEND_FIRST   = 3'd1;
   localparam logic [2:0] EV_SEND_AUTH    = 3'd2;
   localparam logic [2:0] EV_SEND_CONNECT = 3'd3;
   localparam logic [2:0] EV_CONNECTED    = 3'd4;
   localparam logic [2:0] EV_FAILED       = 3'd5;

   // failure reasons
   localparam logic [3:0] FL_NONE         = 4'd0;
   localparam logic [3:0] FL_BAD_VERSION  = 4'd1;
   localparam logic [3:0] FL_BAD_AUTH_VER = 4'd2;
   localparam logic [3:0] FL_NO_METHOD    = 4'd3;
   localparam logic [3:0] FL_AUTH_REJECT  = 4'd4;
   localparam logic [3:0] FL_REQ_REJECT   = 4'd5;
   localparam logic [3:0] FL_BAD_ADDRTYPE = 4'd6;
   localparam logic [3:0] FL_SOCKS4_REJ   = 4'd7;
   localparam logic [3:0] FL_BUSY         = 4'd8;

   // configuration register indexes
   localparam logic [1:0] CSR_PROXY_MODE = 2'd0;
   localparam logic [1:0] CSR_OFFER_AUTH = 2'd1;

   // protocol bytes
   localparam logic [7:0] SOCKS5_VERSION = 8'h05;
   localparam logic [7:0] AUTH_VERSION   = 8'h01;
   localparam logic [7:0] ATYP_IPV4      = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
   localparam logic [7:0] ATYP_IPV6      = 8'h04;
   localparam logic [7:0] SOCKS4_GRANTED = 8'h5A;

   // one classified request as it sits in the queue
   typedef struct packed {
      logic       is_start;
      logic       is_zero;
      logic       is_two;
      logic [7:0] data;
   } req_entry_type;

endpackage

@@ src/scrp_front.sv @@
// Front end of the reply parser: classifies each incoming request.
// Depends on scrp_pkg for the queue entry type.
module scrp_front
   import scrp_pkg::*;
(
   input  logic          req_op,
   input  logic [7:0]    req_rx_byte,
   output req_entry_type entry
);

   always_comb begin
      entry.is_start = ~req_op;
      entry.is_zero  = (req_rx_byte == 8'h00);
      entry.is_two   = (req_rx_byte == 8'h02);
      entry.data     = req_rx_byte;
   end

endmodule

@@ src/scrp_fifo.sv @@
// Short request queue between the front end and the handshake engine.
// Depends on scrp_pkg for the entry type.
module scrp_fifo
   import scrp_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  req_entry_type push_data,
   input  logic          pop,
   output req_entry_type pop_data,
   output logic          full,
   output logic          empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   req_entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_COUNT);
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count out of range");

endmodule

@@ src/scrp_back.sv @@
// Handshake engine: phase tracking, chunk counting, reply checks and the
// registered result stage. Depends on scrp_pkg for codes and entry type.
module scrp_back
   import scrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_data,
   input  logic          q_empty,
   input  req_entry_type q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_event_res,
   output logic [3:0]    rsp_failure,
   output logic [7:0]    rsp_reply_code,
   output logic [1:0]    rsp_method_count
);

   localparam logic [1:0] LS_IDLE      = 2'd0;
   localparam logic [1:0] LS_HANDSHAKE = 2'd1;
   localparam logic [1:0] LS_CONNECTED = 2'd2;

   localparam logic [2:0] PH_METHOD   = 3'd0;
   localparam logic [2:0] PH_AUTH     = 3'd1;
   localparam logic [2:0] PH_REQUEST  = 3'd2;
   localparam logic [2:0] PH_ADDRTYPE = 3'd3;
   localparam logic [2:0] PH_ADDRESS  = 3'd4;
   localparam logic [2:0] PH_SOCKS4   = 3'd5;

   logic       mode_ff, auth_ff;
   logic [1:0] link_ff, link_in;
   logic [2:0] phase_ff, phase_in;
   logic [8:0] idx_ff, idx_in;
   logic [8:0] len_ff, len_in;
   logic [7:0] saved_ff, saved_in;

   logic       out_valid_ff, out_valid_in;
   logic [2:0] ev_ff, ev_in;
   logic [3:0] fl_ff, fl_in;
   logic [7:0] code_ff, code_in;
   logic [1:0] mc_ff, mc_in;

   logic       last;
   logic [8:0] idx_next;

   // take the head of the queue whenever the result stage can load
   assign q_pop    = !q_empty && (!out_valid_ff || !rsp_stall);
   assign idx_next = idx_ff + 9'd1;
   assign last     = ({1'b0, idx_ff} + 10'd1) >= {1'b0, len_ff};

   always_comb begin
      link_in  = link_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      saved_in = saved_ff;
      ev_in    = EV_NONE;
      fl_in    = FL_NONE;
      code_in  = 8'h00;
      mc_in    = 2'd0;

      if (q_data.is_start) begin
         if (link_ff != LS_IDLE) begin
            ev_in = EV_FAILED;
            fl_in = FL_BUSY;
         end else begin
            link_in  = LS_HANDSHAKE;
            saved_in = 8'h00;
            idx_in   = 9'd0;
            ev_in    = EV_SEND_FIRST;
            if (mode_ff) begin
               phase_in = PH_SOCKS4;
               len_in   = 9'd8;
            end else begin
               phase_in = PH_METHOD;
               len_in   = 9'd2;
               mc_in    = auth_ff ? 2'd2 : 2'd1;
            end
         end
      end else if (link_ff == LS_HANDSHAKE) begin
         unique case (phase_ff) inside
            PH_METHOD, PH_AUTH, PH_REQUEST: begin
               if (!last) begin
                  saved_in = q_data.data;
                  idx_in   = idx_next;
               end else if (phase_ff == PH_AUTH) begin
                  if (saved_ff != AUTH_VERSION) begin
                     link_in = LS_IDLE;
                     ev_in   = EV_FAILED;
                     fl_in   = FL_BAD_AUTH_VER;
                     code_in = saved_ff;
                  end else if (!q_data.is_zero) begin
                     link_in = LS_IDLE;
                     ev_in   = EV_FAILED;
                     fl_in   = FL_AUTH_REJECT;
                     code_in = q_data.data;
                  end else begin
                     phase_in = PH_REQUEST;
                     len_in   = 9'd2;
                     idx_in   = 9'd0;
                     ev_in    = EV_SEND_CONNECT;
                  end
               end else if (saved_ff != SOCKS5_VERSION) begin
                  link_in = LS_IDLE;
                  ev_in   = EV_FAILED;
                  fl_in   = FL_BAD_VERSION;
                  code_in = saved_ff;
               end else if (phase_ff == PH_METHOD) begin
                  if (q_data.is_zero) begin
                     phase_in = PH_REQUEST;
                     len_in   = 9'd2;
                     idx_in   = 9'd0;
                     ev_in    = EV_SEND_CONNECT;
                  end else if (q_data.is_two) begin
                     phase_in = PH_AUTH;
                     len_in   = 9'd2;
                     idx_in   = 9'd0;
                     ev_in    = EV_SEND_AUTH;
                  end else begin
                     link_in = LS_IDLE;
                     ev_in   = EV_FAILED;
                     fl_in   = FL_NO_METHOD;
                     code_in = q_data.data;
                  end
               end else if (!q_data.is_zero) begin
                  link_in = LS_IDLE;
                  ev_in   = EV_FAILED;
                  fl_in   = FL_REQ_REJECT;
                  code_in = q_data.data;
               end else begin
                  phase_in = PH_ADDRTYPE;
                  len_in   = 9'd3;
                  idx_in   = 9'd0;
               end
            end
            PH_ADDRTYPE: begin
               if (!last) begin
                  if (idx_ff == 9'd1) begin
                     saved_in = q_data.data;
                  end
                  idx_in = idx_next;
               end else if (saved_ff == ATYP_IPV4) begin
                  phase_in = PH_ADDRESS;
                  len_in   = 9'd5;
                  idx_in   = 9'd0;
               end else if (saved_ff == ATYP_DOMAIN) begin
                  // name bytes plus the two port bytes
                  phase_in = PH_ADDRESS;
                  len_in   = {1'b0, q_data.data} + 9'd2;
                  idx_in   = 9'd0;
               end else if (saved_ff == ATYP_IPV6) begin
                  phase_in = PH_ADDRESS;
                  len_in   = 9'd17;
                  idx_in   = 9'd0;
               end else begin
                  link_in = LS_IDLE;
                  ev_in   = EV_FAILED;
                  fl_in   = FL_BAD_ADDRTYPE;
                  code_in = saved_ff;
               end
            end
            PH_ADDRESS: begin
               if (!last) begin
                  idx_in = idx_next;
               end else begin
                  idx_in  = 9'd0;
                  link_in = LS_CONNECTED;
                  ev_in   = EV_CONNECTED;
               end
            end
            PH_SOCKS4: begin
               if (!last) begin
                  if (idx_ff == 9'd1) begin
                     saved_in = q_data.data;
                  end
                  idx_in = idx_next;
               end else begin
                  idx_in = 9'd0;
                  if (saved_ff != SOCKS4_GRANTED) begin
                     link_in = LS_IDLE;
                     ev_in   = EV_FAILED;
                     fl_in   = FL_SOCKS4_REJ;
                     code_in = saved_ff;
                  end else begin
                     link_in = LS_CONNECTED;
                     ev_in   = EV_CONNECTED;
                  end
               end
            end
            default: begin
               link_in = LS_IDLE;
               ev_in   = EV_FAILED;
               fl_in   = FL_BAD_VERSION;
            end
         endcase
      end
   end

   always_comb begin
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         auth_ff      <= 1'b0;
         link_ff      <= LS_IDLE;
         phase_ff     <= PH_METHOD;
         idx_ff       <= 9'd0;
         len_ff       <= 9'd2;
         saved_ff     <= 8'h00;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_index == CSR_PROXY_MODE) begin
            mode_ff <= csr_data[0];
         end
         if (csr_valid && csr_index == CSR_OFFER_AUTH) begin
            auth_ff <= csr_data[0];
         end
         if (q_pop) begin
            link_ff  <= link_in;
            phase_ff <= phase_in;
            idx_ff   <= idx_in;
            len_ff   <= len_in;
            saved_ff <= saved_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ev_ff   <= ev_in;
         fl_ff   <= fl_in;
         code_ff <= code_in;
         mc_ff   <= mc_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_res    = ev_ff;
   assign rsp_failure      = fl_ff;
   assign rsp_reply_code   = code_ff;
   assign rsp_method_count = mc_ff;

   a_idx_in_chunk: assert property (@(posedge clock) disable iff (reset)
      idx_ff < len_ff)
      else $error("byte position past end of chunk");

   a_fail_has_reason: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((ev_ff == EV_FAILED) == (fl_ff != FL_NONE)))
      else $error("failure reason does not match event");

   a_count_on_first: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && mc_ff != 2'd0) |-> (ev_ff == EV_SEND_FIRST))
      else $error("method count outside a send-first result");

   a_connected_sticks: assert property (@(posedge clock) disable iff (reset)
      (link_ff == LS_CONNECTED) |=> (link_ff == LS_CONNECTED))
      else $error("connected link left its state");

   a_link_legal: assert property (@(posedge clock) disable iff (reset)
      link_ff != 2'd3)
      else $error("link state code with no meaning");

endmodule

@@ src/socks_client_reply_parser_core.sv @@
// Top level of the SOCKS client reply parser.
// Depends on scrp_pkg, scrp_front, scrp_fifo and scrp_back.
//
// Usage:
//   req_*  : one request per accepted edge (req_valid high, req_stall low).
//            req_op 0 starts a handshake, req_op 1 delivers one byte that
//            came back from the proxy in req_rx_byte.
//   rsp_*  : exactly one result per request, in order, accepted when
//            rsp_valid is high and rsp_stall is low.
//   csr_*  : register writes, always ready; index 0 proxy_mode (bit 0),
//            index 1 offer_auth (bit 0). Write only while idle.
// Path: an accepted request is written into the queue; the engine then takes
//   it from the queue head into the result register, which drives rsp_valid,
//   once the result register is empty or its result is being taken.
// Throughput: one request per cycle, sustained while rsp_stall is low. The
//   engine updates its phase and byte counter once per request; the queue of
//   QUEUE_DEPTH entries absorbs bursts while rsp_stall is high.
// Stall: while rsp_stall holds with rsp_valid high, the result register holds,
//   the engine stops and the queue fills; req_stall rises once the queue is full.
// Reset: synchronous, clears registers to SOCKS5 with no auth offered,
//   the link to idle and the queue to empty. No clearing pass is needed.
module socks_client_reply_parser_core
   import scrp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_op,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [3:0] rsp_failure,
   output logic [7:0] rsp_reply_code,
   output logic [1:0] rsp_method_count,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   req_entry_type front_entry;
   req_entry_type head_entry;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;
   logic          q_push;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   // hold off the sender only when the queue has no room
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   scrp_front u_front (
      .req_op      (req_op),
      .req_rx_byte (req_rx_byte),
      .entry       (front_entry)
   );

   scrp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_entry),
      .pop       (q_pop),
      .pop_data  (head_entry),
      .full      (q_full),
      .empty     (q_empty)
   );

   scrp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_empty          (q_empty),
      .q_data           (head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_failure      (rsp_failure),
      .rsp_reply_code   (rsp_reply_code),
      .rsp_method_count (rsp_method_count)
   );

endmodule
